// ===== hw/rtl/crc16fr_pkg.sv =====
// shared types, constants and byte functions of the crc16 frame receiver
package crc16fr_pkg;

	localparam int unsigned MaxLengthLimitDefault = 1024;
	localparam int unsigned MaxLengthWidth = 11;
	localparam int unsigned CountWidth = 11;

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;
	localparam logic [7:0] HdrByte0 = 8'hAA;
	localparam logic [7:0] HdrByte1 = 8'hFF;
	localparam logic [7:0] TailByte = 8'h0D;

	localparam logic KindByte = 1'b0;
	localparam logic KindEnd = 1'b1;

	typedef enum logic [8:0] {
		PH_HUNT_AA = 9'b000000001,
		PH_HUNT_FF = 9'b000000010,
		PH_CMD     = 9'b000000100,
		PH_LEN_HI  = 9'b000001000,
		PH_LEN_LO  = 9'b000010000,
		PH_PAYLOAD = 9'b000100000,
		PH_CRC_LO  = 9'b001000000,
		PH_CRC_HI  = 9'b010000000,
		PH_TAIL    = 9'b100000000
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD       = 2'd0,
		ST_CRC_BAD    = 2'd1,
		ST_TAIL_BAD   = 2'd2,
		ST_OVER_LIMIT = 2'd3
	} frame_status_t;

	typedef struct packed {
		logic          kind;
		logic [7:0]    byte_value;
		logic [7:0]    command;
		logic [15:0]   payload_length;
		frame_status_t status;
	} result_t;

	// crc-16/modbus, one byte, reflected
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// header hunt step for the two hunting phases
	function automatic phase_t hunt_next(input phase_t ph, input logic [7:0] b);
		phase_t n;
		n = PH_HUNT_AA;
		case (ph)
			PH_HUNT_AA: begin
				n = (b == HdrByte0) ? PH_HUNT_FF : PH_HUNT_AA;
			end
			PH_HUNT_FF: begin
				if (b == HdrByte1) begin
					n = PH_CMD;
				end else if (b == HdrByte0) begin
					n = PH_HUNT_FF;
				end else begin
					n = PH_HUNT_AA;
				end
			end
			default: begin
				n = PH_HUNT_AA;
			end
		endcase
		return n;
	endfunction

endpackage

// ===== hw/rtl/crc16fr_in_stage.sv =====
// input register stage holding one received byte
module crc16fr_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       take,
	output logic       item_valid,
	output logic [7:0] item_byte
);
	logic       valid_s1;
	logic [7:0] byte_s1;

	assign in_ready = !valid_s1 || take;
	assign item_valid = valid_s1;
	assign item_byte = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

// ===== hw/rtl/crc16fr_deframer.sv =====
// frame state, crc check and result register
module crc16fr_deframer #(
	parameter int unsigned MAX_LENGTH_LIMIT = crc16fr_pkg::MaxLengthLimitDefault
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   item_valid,
	input  logic [7:0]                             item_byte,
	output logic                                   take,
	input  logic [crc16fr_pkg::MaxLengthWidth-1:0] max_length,
	output logic                                   res_valid,
	input  logic                                   res_ready,
	output crc16fr_pkg::result_t                   res
);
	import crc16fr_pkg::*;

	localparam logic [15:0] LimitP = 16'(MAX_LENGTH_LIMIT);

	phase_t                phase_q, phase_d;
	logic [7:0]            cmd_q, cmd_d;
	logic [15:0]           len_q, len_d;
	logic [CountWidth-1:0] count_q, count_d;
	logic [CountWidth-1:0] count_inc;
	logic [15:0]           crc_q, crc_d;
	logic [15:0]           crc_b, crc_fresh;
	logic [15:0]           limit, max_ext, len_full;
	phase_t                scan1, scan2;
	logic                  has_result, over_limit;
	result_t               res_d, res_q;
	logic                  res_valid_q;

	assign max_ext = 16'(max_length);
	assign limit = (max_ext < LimitP) ? max_ext : LimitP;
	assign crc_b = crc_update(crc_q, item_byte);
	assign crc_fresh = crc_update(CrcInit, item_byte);
	assign len_full = {len_q[15:8], item_byte};
	assign count_inc = count_q + 1'b1;
	// rescan of held command and length high byte after an oversize length
	assign scan1 = hunt_next(PH_HUNT_AA, cmd_q);
	assign scan2 = hunt_next(scan1, len_q[15:8]);

	always_comb begin
		phase_d = phase_q;
		cmd_d = cmd_q;
		len_d = len_q;
		count_d = count_q;
		crc_d = crc_q;
		has_result = 1'b0;
		over_limit = 1'b0;
		res_d.kind = KindByte;
		res_d.byte_value = 8'h00;
		res_d.command = cmd_q;
		res_d.payload_length = len_q;
		res_d.status = ST_GOOD;
		case (phase_q)
			PH_HUNT_AA, PH_HUNT_FF: begin
				phase_d = hunt_next(phase_q, item_byte);
			end
			PH_CMD: begin
				cmd_d = item_byte;
				crc_d = crc_fresh;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d = {item_byte, 8'h00};
				crc_d = crc_b;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d = len_full;
				crc_d = crc_b;
				count_d = '0;
				if (len_full > limit) begin
					over_limit = 1'b1;
					has_result = 1'b1;
					res_d.kind = KindEnd;
					res_d.payload_length = len_full;
					res_d.status = ST_OVER_LIMIT;
					if (scan2 == PH_CMD) begin
						cmd_d = item_byte;
						crc_d = crc_fresh;
						phase_d = PH_LEN_HI;
					end else begin
						phase_d = hunt_next(scan2, item_byte);
					end
				end else begin
					phase_d = (len_full == 16'h0000) ? PH_CRC_LO : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				crc_d = crc_b;
				count_d = count_inc;
				if (16'(count_inc) >= len_q) begin
					phase_d = PH_CRC_LO;
				end
				has_result = 1'b1;
				res_d.byte_value = item_byte;
			end
			PH_CRC_LO: begin
				crc_d = crc_b;
				phase_d = PH_CRC_HI;
			end
			PH_CRC_HI: begin
				crc_d = crc_b;
				phase_d = PH_TAIL;
			end
			PH_TAIL: begin
				has_result = 1'b1;
				res_d.kind = KindEnd;
				if (crc_q != 16'h0000) begin
					res_d.status = ST_CRC_BAD;
				end else if (item_byte != TailByte) begin
					res_d.status = ST_TAIL_BAD;
				end else begin
					res_d.status = ST_GOOD;
				end
				phase_d = PH_HUNT_AA;
			end
			default: begin
				phase_d = PH_HUNT_AA;
			end
		endcase
	end

	// bytes without a result never wait on the output side
	assign take = item_valid && (!has_result || !res_valid_q || res_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT_AA;
			cmd_q <= 8'h00;
			len_q <= 16'h0000;
			count_q <= '0;
			crc_q <= CrcInit;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q <= phase_d;
				cmd_q <= cmd_d;
				len_q <= len_d;
				count_q <= count_d;
				crc_q <= crc_d;
			end
			if (take && has_result) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && has_result) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	a_byte_status_good: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.kind == KindByte |-> res_q.status == ST_GOOD)
		else $error("payload byte result carries a frame status");

	a_end_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.kind == KindEnd |-> res_q.byte_value == 8'h00)
		else $error("end result carries a nonzero byte");

	a_rescan_phase: assert property (@(posedge clk) disable iff (!arst_n)
		take && over_limit |=> phase_q == PH_HUNT_AA || phase_q == PH_HUNT_FF ||
			phase_q == PH_CMD || phase_q == PH_LEN_HI)
		else $error("rescan left the header hunt");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> 16'(count_q) < len_q)
		else $error("payload count reached length while still in payload");

endmodule

// ===== hw/rtl/crc16_frame_receiver_top.sv =====
// crc16 frame receiver: byte deframer with crc-16/modbus check
// a result is offered on out_valid from the deframer result register, after its byte has passed the input register
// stage; throughput: one byte per cycle while no result is stalled; bytes that give no result are never held by a stall
// a stalled result blocks the next byte that itself gives a result, and the bytes queued behind that byte
// reset: arst_n clears to header hunt, crc all ones, max_length to min(limit, 2047)
module crc16_frame_receiver_top #(
	parameter int unsigned MAX_LENGTH_LIMIT = crc16fr_pkg::MaxLengthLimitDefault
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   rx_valid,
	output logic                                   rx_ready,
	input  logic [7:0]                             rx_byte,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic                                   kind,
	output logic [7:0]                             byte_value,
	output logic [7:0]                             command,
	output logic [15:0]                            payload_length,
	output logic [1:0]                             frame_status,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [crc16fr_pkg::MaxLengthWidth-1:0] max_length
);
	import crc16fr_pkg::*;

	localparam int unsigned MaxLenTop = (1 << MaxLengthWidth) - 1;
	localparam logic [MaxLengthWidth-1:0] MaxLenReset = (MAX_LENGTH_LIMIT > MaxLenTop) ?
		MaxLengthWidth'(MaxLenTop) : MaxLengthWidth'(MAX_LENGTH_LIMIT);

	logic [MaxLengthWidth-1:0] max_length_q;
	logic                      item_valid;
	logic [7:0]                item_byte;
	logic                      take;
	result_t                   res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MaxLenReset;
		end else if (cfg_valid && cfg_ready) begin
			max_length_q <= max_length;
		end
	end

	crc16fr_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (rx_valid),
		.in_ready   (rx_ready),
		.in_byte    (rx_byte),
		.take       (take),
		.item_valid (item_valid),
		.item_byte  (item_byte)
	);

	crc16fr_deframer #(
		.MAX_LENGTH_LIMIT (MAX_LENGTH_LIMIT)
	) u_deframer (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_byte  (item_byte),
		.take       (take),
		.max_length (max_length_q),
		.res_valid  (out_valid),
		.res_ready  (out_ready),
		.res        (res)
	);

	assign kind = res.kind;
	assign byte_value = res.byte_value;
	assign command = res.command;
	assign payload_length = res.payload_length;
	assign frame_status = res.status;

endmodule
